// ----- sv/wlps_pkg.sv -----
// Package: shared constants and widths of the windowed latency percentile unit.
package wlps_pkg;

  localparam int WINDOW       = 256;
  localparam int NUM_CHANNELS = 8;

  localparam int CH_W   = 3;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = 9;
  localparam int VAL_W  = 31;
  localparam int SMP_W  = 32;
  localparam int ADDR_W = CH_W + IDX_W;
  localparam int SUM_W  = VAL_W + IDX_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  // rank = (p*(n-1)+50)/100, the divide by 100 done as multiply by 5243 >> 19
  localparam int T_W     = 15;
  localparam int RECIP_W = 13;
  localparam int RSH     = 19;
  localparam int P_W     = T_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP100 = RECIP_W'(5243);

  localparam logic [1:0] MODE_RECORD   = 2'd0;
  localparam logic [1:0] MODE_SNAPSHOT = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

endpackage

// ----- sv/wlps_req_if.sv -----
// Interface: request channel carrying record, snapshot and clear transactions.
interface wlps_req_if import wlps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [CH_W-1:0]         channel;
  logic signed [SMP_W-1:0] sample_value;

  modport source (output valid, mode, channel, sample_value, input ready);
  modport sink   (input valid, mode, channel, sample_value, output ready);
endinterface

// ----- sv/wlps_rsp_if.sv -----
// Interface: result channel carrying one channel's statistics per transaction.
interface wlps_rsp_if import wlps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_channel;
  logic [CNT_W-1:0] sample_count;
  logic [VAL_W-1:0] mean_value;
  logic [VAL_W-1:0] median_value;
  logic [VAL_W-1:0] p95_value;
  logic [VAL_W-1:0] p99_value;
  logic [VAL_W-1:0] max_value;
  logic             last_of_snapshot;

  modport source (output valid, out_channel, sample_count, mean_value, median_value,
                  p95_value, p99_value, max_value, last_of_snapshot, input ready);
  modport sink   (input valid, out_channel, sample_count, mean_value, median_value,
                  p95_value, p99_value, max_value, last_of_snapshot, output ready);
endinterface

// ----- sv/windowed_latency_percentile_stats_unit.sv -----
// Top level: per-channel sample windows with snapshot percentile statistics.
// Record and clear transactions leave the request side ready again in the next cycle.
// A snapshot steps, per non-empty channel, through find, rank setup, rank counting of each
// sample as a candidate over the one sample memory read port, the divider, and output;
// empty channels are skipped one by one.
// The request side is not ready until the last result of a snapshot is taken.
// Synchronous reset empties every channel; sample memory contents are not cleared.
module windowed_latency_percentile_stats_unit import wlps_pkg::*; (
  input logic       clk,
  input logic       rst,
  wlps_req_if.sink  req,
  wlps_rsp_if.source rsp
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIND  = 4'd1;
  localparam logic [3:0] S_RANK  = 4'd2;
  localparam logic [3:0] S_CAND  = 4'd3;
  localparam logic [3:0] S_CWAIT = 4'd4;
  localparam logic [3:0] S_SWEEP = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;

  // per-channel window state
  logic [IDX_W-1:0] write_slot [NUM_CHANNELS];
  logic [CNT_W-1:0] held_count [NUM_CHANNELS];

  // sample memory
  logic [VAL_W-1:0]  store [WINDOW*NUM_CHANNELS];
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rdata;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  // sequencer registers
  logic [CH_W-1:0]   ch_idx;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  cand_i;
  logic [CNT_W-1:0]  sweep_j;
  logic              pend;
  logic [VAL_W-1:0]  cand;
  logic [CNT_W-1:0]  lt_cnt;
  logic [CNT_W-1:0]  le_cnt;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  rem;
  logic [DCNT_W-1:0] div_cnt;
  logic [T_W-1:0]    t50, t95, t99;
  logic [CNT_W-1:0]  r50, r95, r99;
  logic              later_nonempty;

  logic accept;
  logic [CNT_W:0] rem_sh;
  logic           rem_ge;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);

  // record path
  always_comb begin
    wr_en = accept && (req.mode == MODE_RECORD) && !req.sample_value[SMP_W-1] &&
            (32'(req.channel) < NUM_CHANNELS);
    wr_addr = {req.channel, write_slot[req.channel]};
  end

  // memory read address: candidate fetch or sweep fetch
  always_comb begin
    if (state == S_CAND) begin
      rd_addr = {ch_idx, cand_i[IDX_W-1:0]};
    end else begin
      rd_addr = {ch_idx, sweep_j[IDX_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= req.sample_value[VAL_W-1:0];
    end
    rdata <= store[rd_addr];
  end

  // any non-empty channel above the current one
  always_comb begin
    later_nonempty = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if ((c > 32'(ch_idx)) && (held_count[c] != '0)) begin
        later_nonempty = 1'b1;
      end
    end
  end

  // divider step
  assign rem_sh = {rem, sum_q[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, n});

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        write_slot[c] <= '0;
        held_count[c] <= '0;
      end
    end else if (accept && req.mode == MODE_CLEAR) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        write_slot[c] <= '0;
        held_count[c] <= '0;
      end
    end else if (wr_en) begin
      write_slot[req.channel] <= write_slot[req.channel] + 1'b1;
      if (held_count[req.channel] < CNT_W'(WINDOW)) begin
        held_count[req.channel] <= held_count[req.channel] + 1'b1;
      end
    end
  end

  // snapshot sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && req.mode == MODE_SNAPSHOT) begin
            ch_idx <= '0;
            state  <= S_FIND;
          end
        end
        S_FIND: begin
          if (held_count[ch_idx] != '0) begin
            n      <= held_count[ch_idx];
            t50    <= T_W'(50 * (32'(held_count[ch_idx]) - 1) + 50);
            t95    <= T_W'(95 * (32'(held_count[ch_idx]) - 1) + 50);
            t99    <= T_W'(99 * (32'(held_count[ch_idx]) - 1) + 50);
            cand_i <= '0;
            sum_q  <= '0;
            state  <= S_RANK;
          end else if (32'(ch_idx) == NUM_CHANNELS - 1) begin
            state <= S_IDLE;
          end else begin
            ch_idx <= ch_idx + 1'b1;
          end
        end
        S_RANK: begin
          r50   <= CNT_W'((P_W'(t50) * P_W'(RECIP100)) >> RSH);
          r95   <= CNT_W'((P_W'(t95) * P_W'(RECIP100)) >> RSH);
          r99   <= CNT_W'((P_W'(t99) * P_W'(RECIP100)) >> RSH);
          state <= S_CAND;
        end
        S_CAND: begin
          state <= S_CWAIT;
        end
        S_CWAIT: begin
          cand    <= rdata;
          sweep_j <= '0;
          lt_cnt  <= '0;
          le_cnt  <= '0;
          pend    <= 1'b0;
          state   <= S_SWEEP;
        end
        S_SWEEP: begin
          // issue next read, count the one that returned
          if (sweep_j < n) begin
            sweep_j <= sweep_j + 1'b1;
            pend    <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (rdata < cand) begin
              lt_cnt <= lt_cnt + 1'b1;
            end
            if (rdata <= cand) begin
              le_cnt <= le_cnt + 1'b1;
            end
            if (cand_i == '0) begin
              sum_q <= sum_q + SUM_W'(rdata);
            end
          end else if (sweep_j == n) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // the candidate owns sorted positions lt_cnt .. le_cnt-1
          if (lt_cnt <= r50 && r50 < le_cnt) rsp.median_value <= cand;
          if (lt_cnt <= r95 && r95 < le_cnt) rsp.p95_value    <= cand;
          if (lt_cnt <= r99 && r99 < le_cnt) rsp.p99_value    <= cand;
          if (le_cnt == n)                   rsp.max_value    <= cand;
          if (cand_i == n - 1'b1) begin
            rem     <= '0;
            div_cnt <= DCNT_W'(SUM_W);
            state   <= S_DIV;
          end else begin
            cand_i <= cand_i + 1'b1;
            state  <= S_CAND;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            rsp.mean_value       <= sum_q[VAL_W-1:0];
            rsp.out_channel      <= ch_idx;
            rsp.sample_count     <= n;
            rsp.last_of_snapshot <= !later_nonempty;
            state                <= S_OUT;
          end else begin
            rem     <= rem_ge ? CNT_W'(rem_sh - {1'b0, n}) : rem_sh[CNT_W-1:0];
            sum_q   <= {sum_q[SUM_W-2:0], rem_ge};
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            if (rsp.last_of_snapshot) begin
              state <= S_IDLE;
            end else begin
              ch_idx <= ch_idx + 1'b1;
              state  <= S_FIND;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid) else $error("request ready while a result is pending");

  a_candidate_counted: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (le_cnt > lt_cnt) && (le_cnt <= n))
    else $error("candidate rank bounds inconsistent");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (rsp.sample_count != '0) && (rsp.sample_count <= CNT_W'(WINDOW)))
    else $error("result for an empty channel");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == '0) |=> (state == S_OUT))
    else $error("divider did not hand off to output");

endmodule
